/* rtl/lrc_pkg.sv */
// lrc_pkg: shared constants, types and state codes of the letter row clustering block
`default_nettype none

package lrc_pkg;

    localparam int MAX_ROWS        = 32;
    localparam int MAX_ROW_LETTERS = 255;
    localparam int ROW_TOLERANCE   = 10;

    localparam int Y_W       = 12;
    localparam int TOL_W     = 8;
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COUNT_W   = 8;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic [Y_W-1:0]     ref_y;
        logic [COUNT_W-1:0] count;
    } t_row_entry;

    typedef struct packed {
        logic                 en;
        logic [ROW_IDX_W-1:0] addr;
        t_row_entry           data;
    } t_mem_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* rtl/lrc_if.sv */
// lrc_if: handshake channels for letters, results and the tolerance register
`default_nettype none

interface lrc_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [11:0] top_y;

    modport source (output valid, action, top_y, input ready);
    modport sink   (input valid, action, top_y, output ready);
endinterface

interface lrc_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] row_index;
    logic       new_row;
    logic       dropped;
    logic [5:0] row_count;
    logic [7:0] col_count;

    modport source (output valid, row_index, new_row, dropped, row_count, col_count,
                    input ready);
    modport sink   (input valid, row_index, new_row, dropped, row_count, col_count,
                    output ready);
endinterface

interface lrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] join_tol;

    modport source (output valid, join_tol, input ready);
    modport sink   (input valid, join_tol, output ready);
endinterface

`default_nettype wire

/* rtl/lrc_row_mem.sv */
// lrc_row_mem: row table memory, one write port and one registered read port
`default_nettype none

module lrc_row_mem
    import lrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_mem_wr              i_wr,
    input  wire logic [ROW_IDX_W-1:0] i_rd_addr,
    output t_row_entry                o_rd_data
);

    t_row_entry r_mem [MAX_ROWS];
    t_row_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/letter_row_clustering.sv */
// letter_row_clustering: top level, row search sequencer over the row table memory
// a clear goes from idle straight to the done state; a letter first compares the stored rows
// in the scan state (at most 32), one per cycle from the memory port, unless the table is empty
// a new letter or clear is accepted only in idle, after the done state has passed its result on
// reset: synchronous active low, empties the row table and sets the tolerance to 10;
// the row memory is not cleared, entries at or above the row count are never compared
`default_nettype none

module letter_row_clustering
    import lrc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lrc_item_if.sink      i_item,
    lrc_cfg_if.sink       i_cfg,
    lrc_result_if.source  o_result
);

    t_state               r_state, n_state;
    logic [TOL_W-1:0]     r_tol;
    logic [ROW_CNT_W-1:0] r_rows_used;
    logic [COUNT_W-1:0]   r_widest;
    logic [Y_W-1:0]       r_y, n_y;
    logic [ROW_IDX_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [ROW_IDX_W-1:0] r_idx, n_idx;
    logic [Y_W-1:0]       r_ref, n_ref;
    logic [COUNT_W-1:0]   r_cnt, n_cnt;
    logic                 r_wr_en, n_wr_en;
    logic                 r_new, n_new;
    logic                 r_drop, n_drop;
    logic                 r_clear, n_clear;
    logic                 r_out_valid;
    logic [4:0]           r_out_idx;
    logic                 r_out_new;
    logic                 r_out_drop;
    logic [5:0]           r_out_rows;
    logic [7:0]           r_out_cols;

    t_mem_wr              w_wr;
    logic [ROW_IDX_W-1:0] w_rd_addr;
    t_row_entry           w_rd;
    logic [Y_W-1:0]       w_dist;
    logic                 w_match;
    logic                 w_last;
    logic                 w_full;
    logic                 w_out_free;
    logic                 w_finish;
    logic [COUNT_W-1:0]   w_new_cnt;
    logic [COUNT_W-1:0]   w_widest;
    logic [ROW_CNT_W-1:0] w_rows;

    lrc_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;

    assign w_rd_addr = (r_state == S_IDLE) ? '0 : r_cmp_idx + ROW_IDX_W'(1);

    assign w_dist  = (r_y >= w_rd.ref_y) ? r_y - w_rd.ref_y : w_rd.ref_y - r_y;
    assign w_match = (w_dist <= Y_W'(r_tol));
    assign w_last  = ({1'b0, r_cmp_idx} + ROW_CNT_W'(1)) == r_rows_used;
    assign w_full  = (r_rows_used == ROW_CNT_W'(MAX_ROWS));

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    assign w_new_cnt = (r_cnt < COUNT_W'(MAX_ROW_LETTERS)) ? r_cnt + COUNT_W'(1) : r_cnt;

    always_comb begin
        if (r_clear) begin
            w_widest = '0;
            w_rows   = '0;
        end else begin
            w_widest = (r_wr_en && (w_new_cnt > r_widest)) ? w_new_cnt : r_widest;
            w_rows   = r_rows_used + ROW_CNT_W'(r_new);
        end
    end

    always_comb begin
        w_wr.en         = w_finish && r_wr_en;
        w_wr.addr       = r_idx;
        w_wr.data.ref_y = r_ref;
        w_wr.data.count = w_new_cnt;
    end

    // search sequencer
    always_comb begin
        n_state   = r_state;
        n_y       = r_y;
        n_cmp_idx = r_cmp_idx;
        n_idx     = r_idx;
        n_ref     = r_ref;
        n_cnt     = r_cnt;
        n_wr_en   = r_wr_en;
        n_new     = r_new;
        n_drop    = r_drop;
        n_clear   = r_clear;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_y       = i_item.top_y;
                    n_cmp_idx = '0;
                    n_idx     = '0;
                    n_ref     = i_item.top_y;
                    n_cnt     = '0;
                    n_drop    = 1'b0;
                    if (i_item.action == ACT_CLEAR) begin
                        n_clear = 1'b1;
                        n_wr_en = 1'b0;
                        n_new   = 1'b0;
                        n_state = S_DONE;
                    end else if (r_rows_used == '0) begin
                        n_clear = 1'b0;
                        n_wr_en = 1'b1;
                        n_new   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_clear = 1'b0;
                        n_wr_en = 1'b0;
                        n_new   = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_match) begin
                    n_idx   = r_cmp_idx;
                    n_ref   = w_rd.ref_y;
                    n_cnt   = w_rd.count;
                    n_wr_en = 1'b1;
                    n_state = S_DONE;
                end else if (w_last) begin
                    if (w_full) begin
                        n_drop  = 1'b1;
                        n_idx   = '0;
                    end else begin
                        n_idx   = r_rows_used[ROW_IDX_W-1:0];
                        n_ref   = r_y;
                        n_cnt   = '0;
                        n_wr_en = 1'b1;
                        n_new   = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_cmp_idx = r_cmp_idx + ROW_IDX_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tol       <= TOL_W'(ROW_TOLERANCE);
            r_rows_used <= '0;
            r_widest    <= '0;
            r_out_valid <= 1'b0;
            r_wr_en     <= 1'b0;
            r_new       <= 1'b0;
            r_drop      <= 1'b0;
            r_clear     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr_en <= n_wr_en;
            r_new   <= n_new;
            r_drop  <= n_drop;
            r_clear <= n_clear;
            if (i_cfg.valid) begin
                r_tol <= i_cfg.join_tol;
            end
            if (w_finish) begin
                r_rows_used <= w_rows;
                r_widest    <= w_widest;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y       <= n_y;
        r_cmp_idx <= n_cmp_idx;
        r_idx     <= n_idx;
        r_ref     <= n_ref;
        r_cnt     <= n_cnt;
        if (w_finish) begin
            r_out_idx  <= r_idx;
            r_out_new  <= r_new;
            r_out_drop <= r_drop;
            r_out_rows <= w_rows;
            r_out_cols <= w_widest;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.row_index = r_out_idx;
    assign o_result.new_row   = r_out_new;
    assign o_result.dropped   = r_out_drop;
    assign o_result.row_count = r_out_rows;
    assign o_result.col_count = r_out_cols;

endmodule

`default_nettype wire
